### hw/rtl/clrng_pkg.sv
// ----------------------------------------------------------------------------
// clrng_pkg
// Shared constants, control-word types and microprogram for the combined
// congruential random generator with shuffle table.
// ----------------------------------------------------------------------------
package clrng_pkg;

    // Generator constants
    localparam logic [30:0] MOD_ONE     = 31'd2147483563;
    localparam logic [30:0] MOD_TWO     = 31'd2147483399;
    localparam logic [15:0] MUL_ONE     = 16'd40014;
    localparam logic [15:0] MUL_TWO     = 16'd40692;
    // 2^31 minus each modulus, used to fold the high product bits back down
    localparam logic [7:0]  FOLD_ONE    = 8'd85;
    localparam logic [7:0]  FOLD_TWO    = 8'd249;
    localparam logic [30:0] TOP_VAL     = 31'd2147483562;
    localparam logic [30:0] GEN_TWO_RST = 31'd123456789;
    localparam logic [31:0] SEED_MIN    = 32'h8000_0000;
    localparam logic [30:0] SEED_SAT    = 31'h7FFF_FFFF;

    localparam int TABLE_SIZE_DEF = 32;
    localparam int GEN_W          = 31;
    localparam int MUL_A_W        = 31;
    localparam int MUL_B_W        = 16;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    // Scale of the reciprocal used to find the table slot
    localparam int RECIP_SH       = 37;

    // Micro-addresses
    typedef logic [3:0] t_upc;
    localparam t_upc U_IDLE = 4'd0;
    localparam t_upc U_SEED = 4'd1;
    localparam t_upc U_INIT = 4'd2;
    localparam t_upc U_WMUL = 4'd3;
    localparam t_upc U_WRED = 4'd4;
    localparam t_upc U_D0   = 4'd5;
    localparam t_upc U_D1   = 4'd6;
    localparam t_upc U_D2   = 4'd7;
    localparam t_upc U_D3   = 4'd8;
    localparam t_upc U_D4   = 4'd9;
    localparam t_upc U_D5   = 4'd10;

    typedef enum logic [1:0] {
        A_GEN_ONE,
        A_GEN_TWO,
        A_LAST,
        A_DIV
    } t_asel;

    typedef enum logic [1:0] {
        B_MUL_ONE,
        B_MUL_TWO,
        B_RECIP,
        B_QUOT
    } t_bsel;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_GEN_ONE,
        DST_GEN_TWO
    } t_dst;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_SEED,
        ACT_INIT,
        ACT_WARM,
        ACT_QUOT,
        ACT_SLOT,
        ACT_FINISH
    } t_act;

    typedef enum logic [2:0] {
        J_NEXT,
        J_DISPATCH,
        J_LOOP,
        J_OUT,
        J_GOTO
    } t_jump;

    typedef struct packed {
        logic  mul_en;
        t_asel a_sel;
        t_bsel b_sel;
        t_dst  dst;
        t_act  act;
        t_jump jump;
        t_upc  target;
    } t_uword;

    // Microprogram: one control word per step
    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        w = '0;
        case (upc)
            U_IDLE: begin
                w.act  = ACT_ACCEPT;
                w.jump = J_DISPATCH;
            end
            U_SEED: begin
                w.act    = ACT_SEED;
                w.jump   = J_OUT;
                w.target = U_IDLE;
            end
            U_INIT: begin
                w.act = ACT_INIT;
            end
            U_WMUL: begin
                w.mul_en = 1'b1;
                w.a_sel  = A_GEN_ONE;
                w.b_sel  = B_MUL_ONE;
            end
            U_WRED: begin
                w.dst    = DST_GEN_ONE;
                w.act    = ACT_WARM;
                w.jump   = J_LOOP;
                w.target = U_WMUL;
            end
            U_D0: begin
                w.mul_en = 1'b1;
                w.a_sel  = A_GEN_ONE;
                w.b_sel  = B_MUL_ONE;
            end
            U_D1: begin
                w.dst    = DST_GEN_ONE;
                w.mul_en = 1'b1;
                w.a_sel  = A_GEN_TWO;
                w.b_sel  = B_MUL_TWO;
            end
            U_D2: begin
                w.dst    = DST_GEN_TWO;
                w.mul_en = 1'b1;
                w.a_sel  = A_LAST;
                w.b_sel  = B_RECIP;
            end
            U_D3: begin
                w.act    = ACT_QUOT;
                w.mul_en = 1'b1;
                w.a_sel  = A_DIV;
                w.b_sel  = B_QUOT;
            end
            U_D4: begin
                w.act = ACT_SLOT;
            end
            U_D5: begin
                w.act    = ACT_FINISH;
                w.jump   = J_OUT;
                w.target = U_IDLE;
            end
            default: begin
                w.jump   = J_GOTO;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/clrng_ram.sv
// ----------------------------------------------------------------------------
// clrng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clrng_ram #(
    parameter int WIDTH = clrng_pkg::GEN_W,
    parameter int DEPTH = clrng_pkg::TABLE_SIZE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/clrng_modred.sv
// ----------------------------------------------------------------------------
// clrng_modred
// Reduce a 47-bit product modulo one of the two generator moduli. Each
// modulus sits just below 2^31, so the high bits fold back with a small
// constant multiply and one conditional subtract finishes the job.
// ----------------------------------------------------------------------------
module clrng_modred (
    input  logic [clrng_pkg::PROD_W-1:0] i_prod,
    input  logic                         i_sel_two,
    output logic [clrng_pkg::GEN_W-1:0]  o_res
);

    logic [clrng_pkg::MUL_B_W-1:0] hi;
    logic [clrng_pkg::GEN_W-1:0]   lo;
    logic [7:0]                    fold;
    logic [30:0]                   modulus;
    logic [23:0]                   hi_fold;
    logic [31:0]                   folded;

    // Split the product and fold 2^31 as its residue
    always_comb begin
        hi      = i_prod[clrng_pkg::PROD_W-1:clrng_pkg::GEN_W];
        lo      = i_prod[clrng_pkg::GEN_W-1:0];
        fold    = i_sel_two ? clrng_pkg::FOLD_TWO : clrng_pkg::FOLD_ONE;
        modulus = i_sel_two ? clrng_pkg::MOD_TWO : clrng_pkg::MOD_ONE;
        hi_fold = 24'(hi) * 24'(fold);
        folded  = {1'b0, lo} + 32'(hi_fold);
    end

    // Folded value stays below twice the modulus: one subtract is enough
    always_comb begin
        if (folded >= {1'b0, modulus}) begin
            o_res = 31'(folded - {1'b0, modulus});
        end else begin
            o_res = folded[30:0];
        end
    end

endmodule

### hw/rtl/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined congruential uniform generator with a shuffle table, driven by a
// small microprogram over one shared 31x16 multiplier and a modulo folder.
// ----------------------------------------------------------------------------
// One item at a time: a draw makes four sequential passes through the shared
// multiplier plus the table read and update, and a new item is accepted only
// when the sequencer is back in idle. A draw may first initialise the table.
// Reset: synchronous, active low; resets generator state, clears the table valid
// bits and the sequencer at once, with no clearing pass over the table.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = clrng_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_seed_value,
    // Output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_is_sample,
    output logic [30:0]        o_sample,
    output logic signed [31:0] o_seed_state
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 8);
    localparam int Q_W   = $clog2(TABLE_SIZE + 2);
    localparam longint SLOT_DIV_L = 1 + longint'(clrng_pkg::TOP_VAL) / TABLE_SIZE;
    localparam logic [30:0] SLOT_DIV = 31'(SLOT_DIV_L);
    localparam logic [15:0] RECIP =
        16'((longint'(1) << clrng_pkg::RECIP_SH) / SLOT_DIV_L);

    // Sequencer
    clrng_pkg::t_upc   r_upc;
    clrng_pkg::t_upc   n_upc;
    clrng_pkg::t_uword ucw;

    // Datapath registers
    logic [31:0]                  r_gen_one;
    logic [30:0]                  r_gen_two;
    logic [30:0]                  r_last;
    logic [31:0]                  r_seed;
    logic [clrng_pkg::PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]             r_cnt;
    logic [Q_W-1:0]               r_q;
    logic [IDX_W-1:0]             r_slot;
    logic [TABLE_SIZE-1:0]        r_valid;
    logic                         r_rd_valid;

    // Output register
    logic        r_out_valid;
    logic        r_is_sample;
    logic [30:0] r_sample;
    logic [31:0] r_seed_state;

    // Combinational datapath
    logic                        in_acc;
    logic                        out_free;
    logic                        gen_one_nonpos;
    logic [clrng_pkg::MUL_A_W-1:0] mul_a;
    logic [clrng_pkg::MUL_B_W-1:0] mul_b;
    logic [30:0]                 red_res;
    logic                        red_sel_two;
    logic [30:0]                 init_v;
    logic [Q_W-1:0]              quot_est;
    logic [31:0]                 rem;
    logic [Q_W:0]                q_fix;
    logic [IDX_W-1:0]            slot_idx;
    logic [30:0]                 ram_rdata;
    logic [30:0]                 tab_val;
    logic [32:0]                 diff;
    logic [32:0]                 y_full;
    logic [30:0]                 y_res;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [30:0]                 ram_wdata;
    logic                        ram_re;
    logic                        warm_write;
    logic                        out_load;

    // Handshakes
    assign o_stall  = (r_upc != clrng_pkg::U_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign gen_one_nonpos = r_gen_one[31] || (r_gen_one == '0);

    // Control word for this step
    always_comb begin
        ucw = clrng_pkg::ucode(r_upc);
    end

    // Next micro-address
    always_comb begin
        case (ucw.jump)
            clrng_pkg::J_NEXT: begin
                n_upc = r_upc + 4'd1;
            end
            clrng_pkg::J_DISPATCH: begin
                if (!in_acc) begin
                    n_upc = r_upc;
                end else if (i_cmd) begin
                    n_upc = clrng_pkg::U_SEED;
                end else if (gen_one_nonpos) begin
                    n_upc = clrng_pkg::U_INIT;
                end else begin
                    n_upc = clrng_pkg::U_D0;
                end
            end
            clrng_pkg::J_LOOP: begin
                n_upc = (r_cnt != '0) ? ucw.target : r_upc + 4'd1;
            end
            clrng_pkg::J_OUT: begin
                n_upc = out_free ? ucw.target : r_upc;
            end
            clrng_pkg::J_GOTO: begin
                n_upc = ucw.target;
            end
            default: begin
                n_upc = clrng_pkg::U_IDLE;
            end
        endcase
    end

    // Multiplier operand select
    always_comb begin
        case (ucw.a_sel)
            clrng_pkg::A_GEN_ONE: mul_a = r_gen_one[30:0];
            clrng_pkg::A_GEN_TWO: mul_a = r_gen_two;
            clrng_pkg::A_LAST:    mul_a = r_last;
            clrng_pkg::A_DIV:     mul_a = SLOT_DIV;
            default:              mul_a = '0;
        endcase
        case (ucw.b_sel)
            clrng_pkg::B_MUL_ONE: mul_b = clrng_pkg::MUL_ONE;
            clrng_pkg::B_MUL_TWO: mul_b = clrng_pkg::MUL_TWO;
            clrng_pkg::B_RECIP:   mul_b = RECIP;
            clrng_pkg::B_QUOT:    mul_b = 16'(quot_est);
            default:              mul_b = '0;
        endcase
    end

    // Modulo reduction of the registered product
    assign red_sel_two = (ucw.dst == clrng_pkg::DST_GEN_TWO);

    clrng_modred u_modred (
        .i_prod    (r_prod),
        .i_sel_two (red_sel_two),
        .o_res     (red_res)
    );

    // Start value for initialisation: negate, zero becomes one, saturate
    always_comb begin
        if (r_gen_one == '0) begin
            init_v = 31'd1;
        end else if (r_gen_one == clrng_pkg::SEED_MIN) begin
            init_v = clrng_pkg::SEED_SAT;
        end else begin
            init_v = 31'(~r_gen_one + 32'd1);
        end
    end

    // Slot: reciprocal estimate, then one correction step and a clamp
    always_comb begin
        quot_est = r_prod[clrng_pkg::RECIP_SH +: Q_W];
        rem      = {1'b0, r_last} - r_prod[31:0];
        if (rem >= {1'b0, SLOT_DIV}) begin
            q_fix = (Q_W+1)'(r_q) + (Q_W+1)'(1);
        end else begin
            q_fix = (Q_W+1)'(r_q);
        end
        if (q_fix >= (Q_W+1)'(TABLE_SIZE)) begin
            slot_idx = IDX_W'(TABLE_SIZE - 1);
        end else begin
            slot_idx = q_fix[IDX_W-1:0];
        end
    end

    // Combine table entry with the second generator; wrap into range
    always_comb begin
        tab_val = r_rd_valid ? ram_rdata : '0;
        diff    = {2'b00, tab_val} - {2'b00, r_gen_two};
        if (diff[32] || diff == '0) begin
            y_full = diff + {2'b00, clrng_pkg::TOP_VAL};
        end else begin
            y_full = diff;
        end
        y_res = y_full[30:0];
    end

    // Table port control
    always_comb begin
        warm_write = (ucw.act == clrng_pkg::ACT_WARM) && (r_cnt < CNT_W'(TABLE_SIZE));
        out_load   = ((ucw.act == clrng_pkg::ACT_FINISH) ||
                      (ucw.act == clrng_pkg::ACT_SEED)) && out_free;
        ram_we     = warm_write || ((ucw.act == clrng_pkg::ACT_FINISH) && out_free);
        ram_waddr  = warm_write ? r_cnt[IDX_W-1:0] : r_slot;
        ram_wdata  = warm_write ? red_res : r_gen_one[30:0];
        ram_re     = (ucw.act == clrng_pkg::ACT_SLOT);
    end

    clrng_ram #(
        .WIDTH (clrng_pkg::GEN_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (slot_idx),
        .o_rdata (ram_rdata)
    );

    // Sequencer, generator state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc     <= clrng_pkg::U_IDLE;
            r_gen_one <= '0;
            r_gen_two <= clrng_pkg::GEN_TWO_RST;
            r_last    <= '0;
            r_cnt     <= '0;
            r_valid   <= '0;
        end else begin
            r_upc <= n_upc;

            // Write back reduced products
            case (ucw.dst)
                clrng_pkg::DST_GEN_ONE: r_gen_one <= {1'b0, red_res};
                clrng_pkg::DST_GEN_TWO: r_gen_two <= red_res;
                default: ;
            endcase

            case (ucw.act)
                clrng_pkg::ACT_SEED: begin
                    if (out_free) begin
                        r_gen_one <= r_seed;
                    end
                end
                clrng_pkg::ACT_INIT: begin
                    r_gen_one <= {1'b0, init_v};
                    r_gen_two <= init_v;
                    r_cnt     <= CNT_W'(TABLE_SIZE + 7);
                end
                clrng_pkg::ACT_WARM: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (warm_write) begin
                        r_valid[r_cnt[IDX_W-1:0]] <= 1'b1;
                    end
                    if (r_cnt == '0) begin
                        r_last <= red_res;
                    end
                end
                clrng_pkg::ACT_FINISH: begin
                    if (out_free) begin
                        r_last          <= y_res;
                        r_valid[r_slot] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: product, quotient, slot, seed
    always_ff @(posedge i_clk) begin
        if (ucw.mul_en) begin
            r_prod <= clrng_pkg::PROD_W'(mul_a) * clrng_pkg::PROD_W'(mul_b);
        end
        if (ucw.act == clrng_pkg::ACT_QUOT) begin
            r_q <= quot_est;
        end
        if (ucw.act == clrng_pkg::ACT_SLOT) begin
            r_slot     <= slot_idx;
            r_rd_valid <= r_valid[slot_idx];
        end
        if (in_acc) begin
            r_seed <= i_seed_value;
        end
    end

    // Output register: load a finished item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (ucw.act == clrng_pkg::ACT_SEED) begin
                r_is_sample  <= 1'b0;
                r_sample     <= '0;
                r_seed_state <= r_seed;
            end else begin
                r_is_sample  <= 1'b1;
                r_sample     <= y_res;
                r_seed_state <= r_gen_one;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_sample  = r_is_sample;
    assign o_sample     = r_sample;
    assign o_seed_state = r_seed_state;

    // A draw always lands inside the open sample range
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_sample) |-> (o_sample != '0 && o_sample <= clrng_pkg::TOP_VAL))
        else $error("sample out of range");

    // A seed load reports no sample
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_sample) |-> (o_sample == '0))
        else $error("seed load carries a sample");

    // The sequencer leaves idle only on an accepted item
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == clrng_pkg::U_IDLE && !i_valid) |=> (r_upc == clrng_pkg::U_IDLE))
        else $error("sequencer left idle without an item");

    // The warm-up loop ends straight into the draw
    a_warm_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == clrng_pkg::U_WRED && r_cnt == '0) |=> (r_upc == clrng_pkg::U_D0))
        else $error("warm-up loop did not exit to draw");

    // A new result appears only from the seed or final draw step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            ($past(r_upc) == clrng_pkg::U_SEED || $past(r_upc) == clrng_pkg::U_D5))
        else $error("result raised outside a finishing step");

endmodule
